// ===== design/uer_pkg.sv =====
package uer_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_PRE_LOW      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRIG_PULSE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ECHO_TIMEOUT = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_DIST = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_US_PER_UNIT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN     = 3'd5;

	localparam logic [7:0]  RST_PRE_LOW      = 8'd4;
	localparam logic [9:0]  RST_TRIG_PULSE   = 10'd20;
	localparam logic [19:0] RST_ECHO_TIMEOUT = 20'd60000;
	localparam logic [7:0]  RST_TIMEOUT_DIST = 8'd100;
	localparam logic [11:0] RST_US_PER_UNIT  = 12'd148;
	localparam logic [19:0] RST_COOLDOWN     = 20'd200000;

	localparam logic [7:0] DIST_MAX = 8'd255;

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_PRE  = 3'd1,
		PH_TRIG = 3'd2,
		PH_WAIT = 3'd3,
		PH_MEAS = 3'd4,
		PH_COOL = 3'd5
	} phase_t;

	typedef struct packed {
		logic [7:0]  pre_low_us;
		logic [9:0]  trig_pulse_us;
		logic [19:0] echo_timeout_us;
		logic [7:0]  timeout_distance;
		logic [11:0] us_per_unit;
		logic [19:0] cooldown_us;
	} cfg_t;

	// ranger state apart from the phase timer
	typedef struct packed {
		phase_t      phase;
		logic [11:0] unit_subcount;
		logic [7:0]  distance_count;
		logic        last_timed_out;
		logic [7:0]  held_distance;
	} core_t;

endpackage

// ===== design/uer_in_if.sv =====
interface uer_in_if;
	logic valid;
	logic ready;
	logic start_req;
	logic echo;

	modport source (output valid, output start_req, output echo, input ready);
	modport sink (input valid, input start_req, input echo, output ready);
endinterface

// ===== design/uer_out_if.sv =====
interface uer_out_if;
	logic       valid;
	logic       ready;
	logic       trigger;
	logic       busy_res;
	logic       done_res;
	logic [7:0] distance;
	logic       timed_out;

	modport source (output valid, output trigger, output busy_res, output done_res,
		output distance, output timed_out, input ready);
	modport sink (input valid, input trigger, input busy_res, input done_res,
		input distance, input timed_out, output ready);
endinterface

// ===== design/uer_cfg.sv =====
module uer_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [uer_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [uer_pkg::CFG_DATA_W-1:0] cfg_data,
	output uer_pkg::cfg_t                  cfg
);

	uer_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pre_low_us       <= uer_pkg::RST_PRE_LOW;
			cfg_q.trig_pulse_us    <= uer_pkg::RST_TRIG_PULSE;
			cfg_q.echo_timeout_us  <= uer_pkg::RST_ECHO_TIMEOUT;
			cfg_q.timeout_distance <= uer_pkg::RST_TIMEOUT_DIST;
			cfg_q.us_per_unit      <= uer_pkg::RST_US_PER_UNIT;
			cfg_q.cooldown_us      <= uer_pkg::RST_COOLDOWN;
		end else if (cfg_we) begin
			unique case (cfg_index)
				uer_pkg::REG_PRE_LOW:      cfg_q.pre_low_us       <= cfg_data[7:0];
				uer_pkg::REG_TRIG_PULSE:   cfg_q.trig_pulse_us    <= cfg_data[9:0];
				uer_pkg::REG_ECHO_TIMEOUT: cfg_q.echo_timeout_us  <= cfg_data[19:0];
				uer_pkg::REG_TIMEOUT_DIST: cfg_q.timeout_distance <= cfg_data[7:0];
				uer_pkg::REG_US_PER_UNIT:  cfg_q.us_per_unit      <= cfg_data[11:0];
				uer_pkg::REG_COOLDOWN:     cfg_q.cooldown_us      <= cfg_data[19:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== design/uer_step.sv =====
module uer_step #(
	parameter int TIMER_WIDTH = 20
) (
	input  uer_pkg::cfg_t           cfg,
	input  uer_pkg::core_t          cur,
	input  logic [TIMER_WIDTH-1:0]  timer,
	input  logic                    start_req,
	input  logic                    echo,
	output uer_pkg::core_t          nxt,
	output logic [TIMER_WIDTH-1:0]  timer_nxt,
	output logic                    done
);

	localparam int CW = (TIMER_WIDTH > 20) ? TIMER_WIDTH : 20;

	// zero-length pre-low, trigger and cooldown phases fall through to the next one
	function automatic uer_pkg::phase_t enter(uer_pkg::phase_t p, uer_pkg::cfg_t c);
		uer_pkg::phase_t r;
		r = p;
		if (r == uer_pkg::PH_PRE && c.pre_low_us == 8'd0) r = uer_pkg::PH_TRIG;
		if (r == uer_pkg::PH_TRIG && c.trig_pulse_us == 10'd0) r = uer_pkg::PH_WAIT;
		if (r == uer_pkg::PH_COOL && c.cooldown_us == 20'd0) r = uer_pkg::PH_IDLE;
		return r;
	endfunction

	logic [TIMER_WIDTH-1:0] t_inc;
	logic [19:0]            dur;
	logic                   t_end;
	logic [11:0]            sub_inc;
	logic                   sub_hit;
	logic [7:0]             dist_inc;

	always_comb begin
		t_inc = (timer != '1) ? timer + 1'b1 : timer;
		case (cur.phase)
			uer_pkg::PH_PRE:  dur = {12'd0, cfg.pre_low_us};
			uer_pkg::PH_TRIG: dur = {10'd0, cfg.trig_pulse_us};
			uer_pkg::PH_WAIT: dur = cfg.echo_timeout_us;
			default:          dur = cfg.cooldown_us;
		endcase
		t_end = (CW'(t_inc) >= CW'(dur)) || (t_inc == '1);

		sub_inc  = cur.unit_subcount + 12'd1;
		sub_hit  = sub_inc >= cfg.us_per_unit;
		dist_inc = (cur.distance_count < uer_pkg::DIST_MAX) ?
			cur.distance_count + 8'd1 : cur.distance_count;

		nxt       = cur;
		timer_nxt = timer;
		done      = 1'b0;

		unique case (cur.phase)
			uer_pkg::PH_IDLE: begin
				if (start_req) begin
					nxt.phase = enter(uer_pkg::PH_PRE, cfg);
					timer_nxt = '0;
				end
			end
			uer_pkg::PH_PRE: begin
				timer_nxt = t_inc;
				if (t_end) begin
					nxt.phase = enter(uer_pkg::PH_TRIG, cfg);
					timer_nxt = '0;
				end
			end
			uer_pkg::PH_TRIG: begin
				timer_nxt = t_inc;
				if (t_end) begin
					nxt.phase = enter(uer_pkg::PH_WAIT, cfg);
					timer_nxt = '0;
				end
			end
			uer_pkg::PH_WAIT: begin
				if (echo) begin
					// rise tick is the first high microsecond, counted from zero
					nxt.phase = uer_pkg::PH_MEAS;
					timer_nxt = '0;
					if (cfg.us_per_unit <= 12'd1) begin
						nxt.unit_subcount  = 12'd0;
						nxt.distance_count = 8'd1;
					end else begin
						nxt.unit_subcount  = 12'd1;
						nxt.distance_count = 8'd0;
					end
				end else begin
					timer_nxt = t_inc;
					if (t_end) begin
						nxt.held_distance  = cfg.timeout_distance;
						nxt.last_timed_out = 1'b1;
						done               = 1'b1;
						nxt.phase          = uer_pkg::PH_IDLE;
						timer_nxt          = '0;
					end
				end
			end
			uer_pkg::PH_MEAS: begin
				if (echo) begin
					if (sub_hit) begin
						nxt.unit_subcount  = 12'd0;
						nxt.distance_count = dist_inc;
					end else begin
						nxt.unit_subcount = sub_inc;
					end
				end else begin
					nxt.held_distance  = cur.distance_count;
					nxt.last_timed_out = 1'b0;
					done               = 1'b1;
					nxt.phase          = enter(uer_pkg::PH_COOL, cfg);
					timer_nxt          = '0;
				end
			end
			uer_pkg::PH_COOL: begin
				timer_nxt = t_inc;
				if (t_end) begin
					nxt.phase = uer_pkg::PH_IDLE;
					timer_nxt = '0;
				end
			end
			default: begin
				nxt.phase = uer_pkg::PH_IDLE;
				timer_nxt = '0;
			end
		endcase
	end

endmodule

// ===== design/ultrasonic_echo_ranger_unit.sv =====
// channel   dir   payload                                         accepted when
// in_ch     in    start_req, echo                                 valid && ready
// out_ch    out   trigger, busy_res, done_res, distance, timed_out valid && ready
// cfg       in    cfg_index, cfg_data                             cfg_we
//
// one tick in, one result out; a tick is taken every cycle unless in_ch.ready is low
// the ranger state advances in the cycle a tick is taken, result lands in the output register
// in_ch.ready drops only while a result waits in the output register and out_ch is stalled
// asynchronous reset puts the ranger idle with zero distance and registers at their defaults
module ultrasonic_echo_ranger_unit #(
	parameter int TIMER_WIDTH = 20
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [uer_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [uer_pkg::CFG_DATA_W-1:0] cfg_data,
	uer_in_if.sink                         in_ch,
	uer_out_if.source                      out_ch
);

	uer_pkg::cfg_t          cfg;
	uer_pkg::core_t         core_q;
	uer_pkg::core_t         core_nxt;
	logic [TIMER_WIDTH-1:0] timer_q;
	logic [TIMER_WIDTH-1:0] timer_nxt;
	logic                   done;
	logic                   accept;
	logic                   out_valid_q;
	logic                   trigger_q;
	logic                   busy_q;
	logic                   done_q;
	logic [7:0]             distance_q;
	logic                   timed_out_q;

	uer_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	uer_step #(.TIMER_WIDTH(TIMER_WIDTH)) u_step (
		.cfg       (cfg),
		.cur       (core_q),
		.timer     (timer_q),
		.start_req (in_ch.start_req),
		.echo      (in_ch.echo),
		.nxt       (core_nxt),
		.timer_nxt (timer_nxt),
		.done      (done)
	);

	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign accept      = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			core_q.phase          <= uer_pkg::PH_IDLE;
			core_q.unit_subcount  <= 12'd0;
			core_q.distance_count <= 8'd0;
			core_q.last_timed_out <= 1'b0;
			core_q.held_distance  <= 8'd0;
			timer_q               <= '0;
			out_valid_q           <= 1'b0;
		end else begin
			if (accept) begin
				core_q  <= core_nxt;
				timer_q <= timer_nxt;
			end
			if (accept) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			trigger_q   <= core_nxt.phase == uer_pkg::PH_TRIG;
			busy_q      <= core_nxt.phase != uer_pkg::PH_IDLE;
			done_q      <= done;
			distance_q  <= core_nxt.held_distance;
			timed_out_q <= core_nxt.last_timed_out;
		end
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.trigger   = trigger_q;
	assign out_ch.busy_res  = busy_q;
	assign out_ch.done_res  = done_q;
	assign out_ch.distance  = distance_q;
	assign out_ch.timed_out = timed_out_q;

	a_trig_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.trigger |-> out_ch.busy_res)
		else $error("trigger high outside a measurement");

	a_timeout_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && out_ch.done_res && out_ch.timed_out |-> !out_ch.busy_res)
		else $error("timeout result while still busy");

	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		accept && core_q.phase == uer_pkg::PH_IDLE && !in_ch.start_req
		|=> core_q.phase == uer_pkg::PH_IDLE)
		else $error("left idle without a request");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |-> !accept)
		else $error("tick taken while a result is stalled");

endmodule

// ===== dv/ultrasonic_echo_ranger_unit_test.sv =====
`timescale 1ns / 100ps

module ultrasonic_echo_ranger_unit_test;

	localparam int TIMER_W      = 20;
	localparam int LONG_HOLD    = 300;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int RANDOM_TICKS = 200;
	localparam int MAX_PRINTS   = 30;
	localparam int IDX_W        = uer_pkg::CFG_IDX_W;
	localparam int CFG_W        = uer_pkg::CFG_DATA_W;

	// indexes past the register list, writes there change nothing
	localparam logic [IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [IDX_W-1:0] REG_SPARE_7 = 3'd7;

	typedef struct packed {
		logic       trigger;
		logic       busy_res;
		logic       done_res;
		logic [7:0] distance;
		logic       timed_out;
	} reading_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	uer_in_if  in_ch();
	uer_out_if out_ch();

	ultrasonic_echo_ranger_unit #(
		.TIMER_WIDTH(TIMER_W)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ranger shadow
	uer_pkg::cfg_t      ranger_cfg;
	uer_pkg::phase_t    sh_phase;
	logic [TIMER_W-1:0] sh_timer;
	logic [11:0]        sh_subcount;
	logic [7:0]         sh_units;
	logic               sh_timed_out;
	logic [7:0]         sh_distance;

	reading_t expected_readings[$];

	int unsigned error_count;
	int unsigned cycle_count;
	int unsigned ticks_sent;
	int unsigned readings_checked;
	int unsigned distances_seen;
	int unsigned timeouts_seen;
	int unsigned burst_left;
	bit          idle_en;
	bit          long_hold;

	function automatic void ranger_reset();
		ranger_cfg.pre_low_us       = uer_pkg::RST_PRE_LOW;
		ranger_cfg.trig_pulse_us    = uer_pkg::RST_TRIG_PULSE;
		ranger_cfg.echo_timeout_us  = uer_pkg::RST_ECHO_TIMEOUT;
		ranger_cfg.timeout_distance = uer_pkg::RST_TIMEOUT_DIST;
		ranger_cfg.us_per_unit      = uer_pkg::RST_US_PER_UNIT;
		ranger_cfg.cooldown_us      = uer_pkg::RST_COOLDOWN;
		sh_phase     = uer_pkg::PH_IDLE;
		sh_timer     = '0;
		sh_subcount  = '0;
		sh_units     = '0;
		sh_timed_out = 1'b0;
		sh_distance  = '0;
	endfunction

	// zero-length pre-low, trigger and cooldown phases fall through in the same tick
	function automatic void ranger_enter(uer_pkg::phase_t p);
		sh_timer = '0;
		if (p == uer_pkg::PH_PRE && ranger_cfg.pre_low_us == 0) p = uer_pkg::PH_TRIG;
		if (p == uer_pkg::PH_TRIG && ranger_cfg.trig_pulse_us == 0) p = uer_pkg::PH_WAIT;
		if (p == uer_pkg::PH_COOL && ranger_cfg.cooldown_us == 0) p = uer_pkg::PH_IDLE;
		sh_phase = p;
	endfunction

	function automatic bit timer_elapsed(logic [TIMER_W-1:0] dur);
		if (sh_timer != '1) sh_timer++;
		return sh_timer >= dur || sh_timer == '1;
	endfunction

	function automatic void count_echo_us();
		sh_subcount = sh_subcount + 12'd1;
		if (sh_subcount >= ranger_cfg.us_per_unit) begin
			sh_subcount = '0;
			if (sh_units != uer_pkg::DIST_MAX) sh_units++;
		end
	endfunction

	function automatic reading_t ranger_tick(logic start, logic echo);
		reading_t r;
		logic     done;
		done = 1'b0;
		case (sh_phase)
			uer_pkg::PH_IDLE: begin
				if (start) ranger_enter(uer_pkg::PH_PRE);
			end
			uer_pkg::PH_PRE: begin
				if (timer_elapsed(TIMER_W'(ranger_cfg.pre_low_us)))
					ranger_enter(uer_pkg::PH_TRIG);
			end
			uer_pkg::PH_TRIG: begin
				if (timer_elapsed(TIMER_W'(ranger_cfg.trig_pulse_us)))
					ranger_enter(uer_pkg::PH_WAIT);
			end
			uer_pkg::PH_WAIT: begin
				if (echo) begin
					// rising tick is already the first echo microsecond
					sh_subcount = '0;
					sh_units    = '0;
					sh_phase    = uer_pkg::PH_MEAS;
					sh_timer    = '0;
					count_echo_us();
				end else if (timer_elapsed(TIMER_W'(ranger_cfg.echo_timeout_us))) begin
					sh_distance  = ranger_cfg.timeout_distance;
					sh_timed_out = 1'b1;
					done         = 1'b1;
					ranger_enter(uer_pkg::PH_IDLE);
				end
			end
			uer_pkg::PH_MEAS: begin
				if (echo) begin
					count_echo_us();
				end else begin
					sh_distance  = sh_units;
					sh_timed_out = 1'b0;
					done         = 1'b1;
					ranger_enter(uer_pkg::PH_COOL);
				end
			end
			uer_pkg::PH_COOL: begin
				if (timer_elapsed(TIMER_W'(ranger_cfg.cooldown_us)))
					ranger_enter(uer_pkg::PH_IDLE);
			end
			default: begin
				ranger_enter(uer_pkg::PH_IDLE);
			end
		endcase
		r.trigger   = (sh_phase == uer_pkg::PH_TRIG);
		r.busy_res  = (sh_phase != uer_pkg::PH_IDLE);
		r.done_res  = done;
		r.distance  = sh_distance;
		r.timed_out = sh_timed_out;
		return r;
	endfunction

	task automatic flag_mismatch(string what, int unsigned got, int unsigned want);
		error_count++;
		if (error_count <= MAX_PRINTS)
			$display("mismatch on %s: got %0d, expected %0d (cycle %0d)",
				what, got, want, cycle_count);
	endtask

	always @(posedge clk) begin
		reading_t want;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_readings.size() == 0) begin
					flag_mismatch("unexpected result", 1, 0);
				end else begin
					want = expected_readings.pop_front();
					readings_checked++;
					if (want.done_res) begin
						distances_seen++;
						if (want.timed_out) timeouts_seen++;
					end
					if (out_ch.trigger !== want.trigger)
						flag_mismatch("trigger", 32'(out_ch.trigger), 32'(want.trigger));
					if (out_ch.busy_res !== want.busy_res)
						flag_mismatch("busy_res", 32'(out_ch.busy_res), 32'(want.busy_res));
					if (out_ch.done_res !== want.done_res)
						flag_mismatch("done_res", 32'(out_ch.done_res), 32'(want.done_res));
					if (out_ch.distance !== want.distance)
						flag_mismatch("distance", 32'(out_ch.distance), 32'(want.distance));
					if (out_ch.timed_out !== want.timed_out)
						flag_mismatch("timed_out", 32'(out_ch.timed_out),
							32'(want.timed_out));
				end
			end
			if (in_ch.valid && in_ch.ready)
				expected_readings.push_back(ranger_tick(in_ch.start_req, in_ch.echo));
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("ultrasonic_echo_ranger_unit_test failed");
			$finish;
		end
	end

	// result side: rotating stall pattern, plus one long hold-off on request
	initial begin
		logic [15:0] pattern;
		int unsigned pos;
		bit          held_off;
		out_ch.ready <= 1'b0;
		pattern  = 16'hFFFF;
		pos      = 0;
		held_off = 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold && !held_off) begin
				held_off = 1'b1;
				out_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end
			if (pos % 64 == 0) pattern = 16'($urandom) | 16'h0101;
			pos++;
			out_ch.ready <= !idle_en || pattern[pos % 16];
		end
	end

	task automatic send_tick(logic start, logic echo);
		if (idle_en && burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 1)) begin
				in_ch.valid <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end
		end
		if (burst_left > 0) burst_left--;
		in_ch.valid     <= 1'b1;
		in_ch.start_req <= start;
		in_ch.echo      <= echo;
		do @(posedge clk); while (!in_ch.ready);
		ticks_sent++;
	endtask

	task automatic send_run(logic start, logic echo, int unsigned n);
		repeat (n) send_tick(start, echo);
	endtask

	// stop offering items and wait until every result is back
	task automatic settle();
		in_ch.valid <= 1'b0;
		do @(negedge clk); while (expected_readings.size() != 0);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		case (idx)
			uer_pkg::REG_PRE_LOW:      ranger_cfg.pre_low_us       = value[7:0];
			uer_pkg::REG_TRIG_PULSE:   ranger_cfg.trig_pulse_us    = value[9:0];
			uer_pkg::REG_ECHO_TIMEOUT: ranger_cfg.echo_timeout_us  = value[19:0];
			uer_pkg::REG_TIMEOUT_DIST: ranger_cfg.timeout_distance = value[7:0];
			uer_pkg::REG_US_PER_UNIT:  ranger_cfg.us_per_unit      = value[11:0];
			uer_pkg::REG_COOLDOWN:     ranger_cfg.cooldown_us      = value[19:0];
			default: ;
		endcase
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// junk above the register width must be dropped by the block
	function automatic logic [CFG_W-1:0] with_noise(logic [CFG_W-1:0] value,
			int width);
		logic [CFG_W-1:0] keep;
		keep = (CFG_W'(1) << width) - CFG_W'(1);
		return (CFG_W'($urandom) & ~keep) | (value & keep);
	endfunction

	task automatic test_reset_defaults();
		// echo while idle does nothing
		send_run(1'b0, 1'b1, 2);
		send_tick(1'b1, 1'b0);
		// requests during pre-low and trigger are ignored
		send_run(1'b1, 1'b0, 24);
		send_run(1'b0, 1'b1, 3);
		send_tick(1'b0, 1'b0);
		send_run(1'b0, 1'b0, 2);
		settle();
		// shorten the cooldown while the block sits in it
		write_reg(uer_pkg::REG_COOLDOWN, 20'd0);
		send_run(1'b0, 1'b0, 2);
		settle();
	endtask

	task automatic test_skips_and_timeout();
		write_reg(uer_pkg::REG_PRE_LOW, 20'd0);
		write_reg(uer_pkg::REG_TRIG_PULSE, 20'd0);
		write_reg(uer_pkg::REG_ECHO_TIMEOUT, 20'd0);
		send_tick(1'b1, 1'b0);
		send_run(1'b0, 1'b0, 2);
		settle();
		write_reg(uer_pkg::REG_TIMEOUT_DIST, 20'd0);
		write_reg(uer_pkg::REG_ECHO_TIMEOUT, 20'd3);
		write_reg(uer_pkg::REG_TRIG_PULSE, 20'd1);
		write_reg(REG_SPARE_6, '1);
		write_reg(REG_SPARE_7, '1);
		send_tick(1'b1, 1'b0);
		send_run(1'b0, 1'b0, 6);
		settle();
		write_reg(uer_pkg::REG_TIMEOUT_DIST, 20'd255);
		send_tick(1'b1, 1'b1);
		send_run(1'b0, 1'b0, 6);
		settle();
	endtask

	task automatic test_divisor_and_saturation();
		write_reg(uer_pkg::REG_US_PER_UNIT, 20'd0);
		write_reg(uer_pkg::REG_COOLDOWN, 20'd0);
		send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b0);
		send_run(1'b0, 1'b1, 260);
		send_run(1'b0, 1'b0, 2);
		settle();
		write_reg(uer_pkg::REG_US_PER_UNIT, 20'd3);
		write_reg(uer_pkg::REG_COOLDOWN, 20'd4);
		send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b0);
		send_run(1'b0, 1'b1, 10);
		send_run(1'b0, 1'b0, 6);
		settle();
	endtask

	task automatic test_extreme_settings();
		write_reg(uer_pkg::REG_PRE_LOW, 20'd255);
		write_reg(uer_pkg::REG_TRIG_PULSE, 20'd1023);
		write_reg(uer_pkg::REG_ECHO_TIMEOUT, 20'hFFFFF);
		write_reg(uer_pkg::REG_US_PER_UNIT, 20'd4095);
		write_reg(uer_pkg::REG_COOLDOWN, 20'd0);
		send_tick(1'b1, 1'b0);
		send_run(1'b0, 1'b0, 1283);
		send_run(1'b0, 1'b1, 12);
		send_run(1'b0, 1'b0, 2);
		settle();
		write_reg(uer_pkg::REG_PRE_LOW, 20'd0);
		write_reg(uer_pkg::REG_TRIG_PULSE, 20'd1);
		write_reg(uer_pkg::REG_ECHO_TIMEOUT, 20'd2);
		write_reg(uer_pkg::REG_COOLDOWN, 20'hFFFFF);
		// a timeout goes straight back to idle, no cooldown
		send_tick(1'b1, 1'b0);
		send_run(1'b0, 1'b0, 5);
		send_tick(1'b1, 1'b0);
		send_tick(1'b0, 1'b0);
		send_run(1'b0, 1'b1, 2);
		send_run(1'b0, 1'b0, 5);
		settle();
		write_reg(uer_pkg::REG_COOLDOWN, 20'd1);
		send_run(1'b0, 1'b0, 2);
		settle();
	endtask

	task automatic test_random_shots();
		int unsigned first_tick;
		int unsigned pre_v, trig_v, tout_v, cool_v, per_v;
		int unsigned shots, high_len;
		bit          pressure_done;
		first_tick    = ticks_sent;
		pressure_done = 1'b0;
		while (ticks_sent - first_tick < RANDOM_TICKS) begin
			idle_en = ($urandom_range(0, 3) != 0);
			pre_v   = $urandom_range(0, 6);
			trig_v  = $urandom_range(0, 6);
			tout_v  = $urandom_range(0, 25);
			cool_v  = $urandom_range(0, 15);
			per_v   = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1)
				: $urandom_range(1, 12);
			write_reg(uer_pkg::REG_PRE_LOW, with_noise(CFG_W'(pre_v), 8));
			write_reg(uer_pkg::REG_TRIG_PULSE, with_noise(CFG_W'(trig_v), 10));
			write_reg(uer_pkg::REG_ECHO_TIMEOUT, CFG_W'(tout_v));
			write_reg(uer_pkg::REG_TIMEOUT_DIST, with_noise(CFG_W'($urandom), 8));
			write_reg(uer_pkg::REG_US_PER_UNIT, with_noise(CFG_W'(per_v), 12));
			write_reg(uer_pkg::REG_COOLDOWN, CFG_W'(cool_v));
			shots = $urandom_range(2, 6);
			repeat (shots) begin
				// second shot of the first batch runs under the long hold-off
				if (!pressure_done && ticks_sent != first_tick) begin
					long_hold     = 1'b1;
					pressure_done = 1'b1;
				end
				if ($urandom_range(0, 6) == 0) begin
					repeat ($urandom_range(3, 30))
						send_tick($urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)));
				end else begin
					send_tick(1'b1, 1'($urandom_range(0, 1)));
					// low stretch sometimes outlasts the echo timeout
					repeat (pre_v + trig_v + $urandom_range(0, tout_v + 3))
						send_tick($urandom_range(0, 3) == 0, 1'b0);
					high_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
						: $urandom_range(1, 30);
					repeat (high_len) send_tick($urandom_range(0, 3) == 0, 1'b1);
					send_run(1'b0, 1'b0, cool_v + $urandom_range(1, 3));
				end
			end
			settle();
		end
		idle_en = 1'b1;
	endtask

	initial begin
		in_ch.valid     <= 1'b0;
		in_ch.start_req <= 1'b0;
		in_ch.echo      <= 1'b0;
		cfg_we          <= 1'b0;
		cfg_index       <= uer_pkg::REG_PRE_LOW;
		cfg_data        <= '0;
		arst_n          <= 1'b0;
		idle_en    = 1'b1;
		long_hold  = 1'b0;
		burst_left = 0;
		ranger_reset();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_skips_and_timeout();
		test_divisor_and_saturation();
		test_extreme_settings();
		test_random_shots();

		settle();
		repeat (5) @(posedge clk);
		if (expected_readings.size() != 0)
			flag_mismatch("results never delivered", 0, expected_readings.size());
		$display("ran %0d ticks, checked %0d results", ticks_sent, readings_checked);
		$display("%0d distances latched, %0d of them from echo timeouts",
			distances_seen, timeouts_seen);
		if (error_count == 0) begin
			$display("ultrasonic_echo_ranger_unit_test passed");
		end else begin
			$display("ultrasonic_echo_ranger_unit_test failed");
		end
		$finish;
	end

endmodule
